// ===== hdl/hts_pkg.sv =====
// ----------------------------------------------------------------------------
// hts_pkg
// Shared types, character codes and word tables for the tag stripper.
// ----------------------------------------------------------------------------
package hts_pkg;

    localparam int LOOK_DEPTH = 9;
    localparam int ENT_DEPTH  = 6;

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_QUOT  = 8'h22;
    localparam logic [7:0] CH_APOS  = 8'h27;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CASE_BIT = 8'h20;

    localparam logic [7:0] WORD_SCRIPT [6] = '{"s", "c", "r", "i", "p", "t"};
    localparam logic [7:0] WORD_STYLE  [5] = '{"s", "t", "y", "l", "e"};

    localparam logic [7:0] ENT_LT   [4] = '{"&", "l", "t", ";"};
    localparam logic [7:0] ENT_GT   [4] = '{"&", "g", "t", ";"};
    localparam logic [7:0] ENT_AMP  [5] = '{"&", "a", "m", "p", ";"};
    localparam logic [7:0] ENT_QUOT [6] = '{"&", "q", "u", "o", "t", ";"};
    localparam logic [7:0] ENT_APOS [6] = '{"&", "a", "p", "o", "s", ";"};
    localparam logic [7:0] ENT_NBSP [6] = '{"&", "n", "b", "s", "p", ";"};

    // one slot of a window: a byte or a bare end-of-document marker
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       is_byte;
        logic       fin;      // entered while its document was being flushed
    } t_slot;

    typedef struct packed {
        logic  valid;
        t_slot slot;
    } t_cell;

    // decoded event from the entity window
    typedef struct packed {
        logic       valid;
        logic       tok;      // 0: end of document with no byte
        logic       fin;
        logic       last;
        logic [7:0] data;
    } t_ev;

    function automatic logic ci_eq(input logic [7:0] b, input logic [7:0] lower);
        return (b | CASE_BIT) == lower;
    endfunction

endpackage

// ===== hdl/hts_if.sv =====
// ----------------------------------------------------------------------------
// hts_in_if / hts_out_if
// Valid/ready channels for raw text bytes and for decoded results.
// ----------------------------------------------------------------------------
interface hts_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface hts_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_valid;
    logic       out_last;

    modport source (output valid, output out_byte, output out_valid, output out_last,
                    input ready);
    modport sink   (input valid, input out_byte, input out_valid, input out_last,
                    output ready);
endinterface

// ===== hdl/hts_cell.sv =====
// ----------------------------------------------------------------------------
// hts_cell
// One slot of a left-justified shifting window: holds, loads or takes its
// right neighbour on a pop.
// ----------------------------------------------------------------------------
module hts_cell import hts_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_pop,
    input  logic  i_load,
    input  t_slot i_din,
    input  t_cell i_nbr,
    output t_cell o_cell
);

    logic  r_valid, n_valid;
    t_slot r_slot, n_slot;

    always_comb begin
        n_valid = r_valid;
        n_slot  = r_slot;
        if (i_load) begin
            n_valid = 1'b1;
            n_slot  = i_din;
        end else if (i_pop) begin
            n_valid = i_nbr.valid;
            n_slot  = i_nbr.slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

    assign o_cell = '{valid: r_valid, slot: r_slot};

endmodule

// ===== hdl/hts_tag_window.sv =====
// ----------------------------------------------------------------------------
// hts_tag_window
// Nine-cell lookahead window; tracks tag, script and style state and passes
// surviving bytes and end markers on to the entity window.
// ----------------------------------------------------------------------------
module hts_tag_window import hts_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    hts_in_if.sink i_in,
    input  logic   i_s2_ready,
    output t_cell  o_push
);

    t_cell                  w_cell [LOOK_DEPTH];
    t_cell                  w_nbr  [LOOK_DEPTH];
    t_slot                  s      [LOOK_DEPTH];
    logic [LOOK_DEPTH-1:0]  v, v_up, v_dn, dm, load;
    logic                   flush, want, pop, push, keep, is_lt, is_gt;
    logic                   m_open_sc, m_open_st, m_close_sc, m_close_st;
    logic                   sc1, st1, cl_sc, cl_st;
    t_slot                  din;
    logic                   r_tag, r_script, r_style;
    logic                   n_tag, n_script, n_style;

    for (genvar g = 0; g < LOOK_DEPTH; g++) begin : g_cell
        hts_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_pop   (pop),
            .i_load  (load[g]),
            .i_din   (din),
            .i_nbr   (w_nbr[g]),
            .o_cell  (w_cell[g])
        );
    end

    // dm: position holds a byte of the head's document
    always_comb begin
        logic seen;
        seen = 1'b0;
        for (int i = 0; i < LOOK_DEPTH; i++) begin
            v[i]  = w_cell[i].valid;
            s[i]  = w_cell[i].slot;
            dm[i] = v[i] && !seen;
            seen  = seen || (v[i] && s[i].last);
        end
        flush = seen;
        for (int i = 0; i < LOOK_DEPTH - 1; i++) begin
            w_nbr[i] = w_cell[i+1];
        end
        w_nbr[LOOK_DEPTH-1] = '0;
    end

    assign v_up = {1'b0, v[LOOK_DEPTH-1:1]};
    assign v_dn = {v[LOOK_DEPTH-2:0], 1'b1};

    always_comb begin
        m_open_sc  = dm[7];
        m_open_st  = dm[6];
        m_close_sc = dm[LOOK_DEPTH-1] && (s[1].data == CH_SLASH) && (s[8].data == CH_GT);
        m_close_st = dm[LOOK_DEPTH-1] && (s[1].data == CH_SLASH) && (s[7].data == CH_GT);
        for (int k = 0; k < 6; k++) begin
            m_open_sc  = m_open_sc  && ci_eq(s[k+1].data, WORD_SCRIPT[k]);
            m_close_sc = m_close_sc && ci_eq(s[k+2].data, WORD_SCRIPT[k]);
        end
        for (int k = 0; k < 5; k++) begin
            m_open_st  = m_open_st  && ci_eq(s[k+1].data, WORD_STYLE[k]);
            m_close_st = m_close_st && ci_eq(s[k+2].data, WORD_STYLE[k]);
        end
    end

    assign is_lt = (s[0].data == CH_LT);
    assign is_gt = (s[0].data == CH_GT);
    assign sc1   = r_script || (is_lt && m_open_sc);
    assign st1   = r_style  || (is_lt && m_open_st);
    assign cl_sc = sc1 && m_close_sc;
    assign cl_st = !cl_sc && st1 && m_close_st;
    assign keep  = !is_lt && !is_gt && !r_tag && !r_script && !r_style;

    // head is decided once the window is full or its document has ended
    assign want  = v[0] && (v[LOOK_DEPTH-1] || flush);

    assign o_push.valid = want && (keep || s[0].last);
    assign o_push.slot  = '{data: s[0].data, last: s[0].last, is_byte: keep, fin: flush};

    assign pop        = want && (!o_push.valid || i_s2_ready);
    assign i_in.ready = !v[LOOK_DEPTH-1] || pop;
    assign push       = i_in.valid && i_in.ready;
    assign din        = '{data: i_in.in_byte, last: i_in.in_last, is_byte: 1'b1, fin: 1'b0};

    always_comb begin
        for (int i = 0; i < LOOK_DEPTH; i++) begin
            if (pop) begin
                load[i] = push && v[i] && !v_up[i];
            end else begin
                load[i] = push && !v[i] && v_dn[i];
            end
        end
    end

    always_comb begin
        n_tag    = r_tag;
        n_script = r_script;
        n_style  = r_style;
        if (pop) begin
            if (s[0].last) begin
                n_tag    = 1'b0;
                n_script = 1'b0;
                n_style  = 1'b0;
            end else if (is_lt) begin
                n_tag    = 1'b1;
                n_script = sc1 && !cl_sc;
                n_style  = st1 && !cl_st;
            end else if (is_gt) begin
                n_tag    = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag    <= 1'b0;
            r_script <= 1'b0;
            r_style  <= 1'b0;
        end else begin
            r_tag    <= n_tag;
            r_script <= n_script;
            r_style  <= n_style;
        end
    end

endmodule

// ===== hdl/hts_ent_window.sv =====
// ----------------------------------------------------------------------------
// hts_ent_window
// Six-cell entity window; decodes the head and drops the remaining bytes of
// a matched entity one per cycle.
// ----------------------------------------------------------------------------
module hts_ent_window import hts_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cell i_push,
    output logic  o_ready,
    output t_ev   o_ev,
    input  logic  i_ev_ready
);

    t_cell                 w_cell [ENT_DEPTH];
    t_cell                 w_nbr  [ENT_DEPTH];
    t_slot                 s      [ENT_DEPTH];
    logic [ENT_DEPTH-1:0]  v, v_up, v_dn, bm, load;
    logic                  flush, want, pop, push, skipping, ev_last;
    logic                  m_lt, m_gt, m_amp, m_quot, m_apos, m_nbsp;
    logic [7:0]            val;
    logic [2:0]            used;
    logic [2:0]            r_skip, n_skip;

    for (genvar g = 0; g < ENT_DEPTH; g++) begin : g_cell
        hts_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_pop   (pop),
            .i_load  (load[g]),
            .i_din   (i_push.slot),
            .i_nbr   (w_nbr[g]),
            .o_cell  (w_cell[g])
        );
    end

    // bm: position holds a text byte of the head's document
    always_comb begin
        logic seen;
        seen = 1'b0;
        for (int i = 0; i < ENT_DEPTH; i++) begin
            v[i]  = w_cell[i].valid;
            s[i]  = w_cell[i].slot;
            bm[i] = v[i] && s[i].is_byte && !seen;
            seen  = seen || (v[i] && s[i].last);
        end
        flush = seen;
        for (int i = 0; i < ENT_DEPTH - 1; i++) begin
            w_nbr[i] = w_cell[i+1];
        end
        w_nbr[ENT_DEPTH-1] = '0;
    end

    assign v_up = {1'b0, v[ENT_DEPTH-1:1]};
    assign v_dn = {v[ENT_DEPTH-2:0], 1'b1};

    always_comb begin
        m_lt   = bm[3];
        m_gt   = bm[3];
        m_amp  = bm[4];
        m_quot = bm[5];
        m_apos = bm[5];
        m_nbsp = bm[5];
        for (int k = 0; k < 4; k++) begin
            m_lt = m_lt && (s[k].data == ENT_LT[k]);
            m_gt = m_gt && (s[k].data == ENT_GT[k]);
        end
        for (int k = 0; k < 5; k++) begin
            m_amp = m_amp && (s[k].data == ENT_AMP[k]);
        end
        for (int k = 0; k < 6; k++) begin
            m_quot = m_quot && (s[k].data == ENT_QUOT[k]);
            m_apos = m_apos && (s[k].data == ENT_APOS[k]);
            m_nbsp = m_nbsp && (s[k].data == ENT_NBSP[k]);
        end
    end

    always_comb begin
        val  = s[0].data;
        used = 3'd1;
        if (m_lt) begin
            val  = CH_LT;
            used = 3'd4;
        end else if (m_gt) begin
            val  = CH_GT;
            used = 3'd4;
        end else if (m_amp) begin
            val  = CH_AMP;
            used = 3'd5;
        end else if (m_quot) begin
            val  = CH_QUOT;
            used = 3'd6;
        end else if (m_apos) begin
            val  = CH_APOS;
            used = 3'd6;
        end else if (m_nbsp) begin
            val  = CH_SPACE;
            used = 3'd6;
        end
    end

    // the document's final entry can only sit at the end of what is consumed
    always_comb begin
        case (used)
            3'd4:    ev_last = s[3].last;
            3'd5:    ev_last = s[4].last;
            3'd6:    ev_last = s[5].last;
            default: ev_last = s[0].last;
        endcase
    end

    assign skipping = (r_skip != 3'd0);
    assign want     = !skipping && v[0] && (v[ENT_DEPTH-1] || flush);

    assign o_ev.valid = want;
    assign o_ev.tok   = s[0].is_byte;
    assign o_ev.fin   = flush || s[ENT_DEPTH-1].fin;
    assign o_ev.last  = ev_last;
    assign o_ev.data  = val;

    assign pop     = skipping ? v[0] : (want && i_ev_ready);
    assign o_ready = !v[ENT_DEPTH-1] || pop;
    assign push    = i_push.valid && o_ready;

    always_comb begin
        for (int i = 0; i < ENT_DEPTH; i++) begin
            if (pop) begin
                load[i] = push && v[i] && !v_up[i];
            end else begin
                load[i] = push && !v[i] && v_dn[i];
            end
        end
    end

    always_comb begin
        n_skip = r_skip;
        if (pop) begin
            if (skipping) begin
                n_skip = r_skip - 3'd1;
            end else begin
                n_skip = used - 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip <= 3'd0;
        end else begin
            r_skip <= n_skip;
        end
    end

endmodule

// ===== hdl/hts_emit.sv =====
// ----------------------------------------------------------------------------
// hts_emit
// Places the end-of-document flag on the right result and buffers results
// in a two-entry output queue.
// ----------------------------------------------------------------------------
module hts_emit import hts_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_ev        i_ev,
    output logic       o_ev_ready,
    hts_out_if.source  o_out
);

    typedef enum logic [2:0] {
        PS_EMPTY = 3'b001,
        PS_HOLD  = 3'b010,
        PS_SHIP  = 3'b100
    } t_pend_state;

    typedef struct packed {
        logic [7:0] data;
        logic       bval;
        logic       last;
    } t_res;

    localparam logic [1:0] Q_FULL = 2'd2;

    t_pend_state r_state, n_state;
    logic [7:0]  r_pend, n_pend;
    t_res        r_q0, r_q1, n_q0, n_q1, sd;
    logic [1:0]  r_qcnt, n_qcnt;
    logic        space, ship, take, deq;

    assign space = (r_qcnt != Q_FULL);
    assign take  = i_ev.valid && o_ev_ready;

    // results of a flushed document wait here until it is known whether
    // another result of the same document follows
    always_comb begin
        n_state    = r_state;
        n_pend     = r_pend;
        ship       = 1'b0;
        sd         = '0;
        o_ev_ready = 1'b0;
        case (r_state)
            PS_SHIP: begin
                if (space) begin
                    ship    = 1'b1;
                    sd      = '{data: r_pend, bval: 1'b1, last: 1'b1};
                    n_state = PS_EMPTY;
                end
            end
            PS_EMPTY, PS_HOLD: begin
                o_ev_ready = space;
                if (take) begin
                    if (!i_ev.tok) begin
                        ship    = 1'b1;
                        n_state = PS_EMPTY;
                        if (r_state == PS_HOLD) begin
                            sd = '{data: r_pend, bval: 1'b1, last: 1'b1};
                        end else begin
                            sd = '{data: 8'd0, bval: 1'b0, last: 1'b1};
                        end
                    end else if (!i_ev.fin) begin
                        ship = 1'b1;
                        sd   = '{data: i_ev.data, bval: 1'b1, last: i_ev.last};
                    end else begin
                        if (r_state == PS_HOLD) begin
                            ship = 1'b1;
                            sd   = '{data: r_pend, bval: 1'b1, last: 1'b0};
                        end
                        n_pend  = i_ev.data;
                        n_state = i_ev.last ? PS_SHIP : PS_HOLD;
                    end
                end
            end
            default: begin
                n_state = PS_EMPTY;
            end
        endcase
    end

    assign deq = o_out.valid && o_out.ready;

    always_comb begin
        n_q0   = r_q0;
        n_q1   = r_q1;
        n_qcnt = r_qcnt;
        if (deq && ship) begin
            if (r_qcnt == 2'd1) begin
                n_q0 = sd;
            end else begin
                n_q0 = r_q1;
                n_q1 = sd;
            end
        end else if (deq) begin
            n_q0   = r_q1;
            n_qcnt = r_qcnt - 2'd1;
        end else if (ship) begin
            if (r_qcnt == 2'd0) begin
                n_q0 = sd;
            end else begin
                n_q1 = sd;
            end
            n_qcnt = r_qcnt + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= PS_EMPTY;
            r_qcnt  <= 2'd0;
        end else begin
            r_state <= n_state;
            r_qcnt  <= n_qcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        r_q0   <= n_q0;
        r_q1   <= n_q1;
    end

    assign o_out.valid     = (r_qcnt != 2'd0);
    assign o_out.out_byte  = r_q0.data;
    assign o_out.out_valid = r_q0.bval;
    assign o_out.out_last  = r_q0.last;

endmodule

// ===== hdl/html_tag_strip_entity_decode.sv =====
// ----------------------------------------------------------------------------
// html_tag_strip_entity_decode
// Streaming tag stripper with entity decoding, one text byte per request.
// ----------------------------------------------------------------------------
// Takes one byte per cycle unless it holds off the input, and delivers up
// to one result per cycle. A byte passes a nine-cell lookahead window, where
// tags, scripts and styles are removed, then a six-cell entity window, where
// a matched entity is decoded and its remaining bytes are dropped at one
// cell per cycle. A result appears once at least thirteen further bytes of
// the document have arrived (more when bytes are dropped), or when the
// document ends; the marked last byte then drains both windows by themselves
// through the one-slot shift of the cells, while the first bytes of the next
// document already enter behind it. The final result of a document carries
// out_last; a document that ends without a result of its own gives a bare
// end marker. When the last byte of a document survives, its result waits
// in a pending register of the output stage to take the end flag; the
// windows absorb this, but a run of short documents sent back to back can
// hold off the input. Results leave through a two-entry buffer, so input
// acceptance does not depend combinationally on the output ready.
module html_tag_strip_entity_decode import hts_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hts_in_if.sink     i_in,
    hts_out_if.source  o_out
);

    t_cell s1_push;
    logic  s2_ready;
    t_ev   ev;
    logic  ev_ready;

    hts_tag_window u_tag (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_s2_ready (s2_ready),
        .o_push     (s1_push)
    );

    hts_ent_window u_ent (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (s1_push),
        .o_ready    (s2_ready),
        .o_ev       (ev),
        .i_ev_ready (ev_ready)
    );

    hts_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ev       (ev),
        .o_ev_ready (ev_ready),
        .o_out      (o_out)
    );

endmodule

// ===== hdl/hts_checker.sv =====
// ----------------------------------------------------------------------------
// hts_checker
// Port-level checks on the result channel of the tag stripper.
// ----------------------------------------------------------------------------
module hts_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_vld,
    input logic       i_out_rdy,
    input logic [7:0] i_out_byte,
    input logic       i_out_bval,
    input logic       i_out_last
);

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_vld && !i_out_rdy |=> i_out_vld && $stable(i_out_byte)
            && $stable(i_out_bval) && $stable(i_out_last))
        else $error("result changed while stalled");

    // a result without a byte only ever ends a document
    a_bare_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_vld && !i_out_bval |-> i_out_last)
        else $error("bare end marker without last");

    a_bare_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_vld && !i_out_bval |-> i_out_byte == 8'd0)
        else $error("bare end marker with nonzero byte");

    // nothing left queued after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_vld)
        else $error("result pending after reset");

endmodule

bind html_tag_strip_entity_decode hts_checker u_hts_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_out_vld  (o_out.valid),
    .i_out_rdy  (o_out.ready),
    .i_out_byte (o_out.out_byte),
    .i_out_bval (o_out.out_valid),
    .i_out_last (o_out.out_last)
);
